/* rtl/plom_pkg.sv */
// Package for the price level order matcher: widths, report codes,
// controller states and the cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plom_pkg;

    localparam int ID_W        = 32;
    localparam int QTY_W       = 32;
    localparam int KIND_W      = 3;
    localparam int LEFT_W      = 7;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_REPORTS = 16;
    localparam int NREP_W      = $clog2(MAX_REPORTS + 1);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FILL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PARTIAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // Per-cell control: shift toward the head, or load id and/or quantity.
    typedef struct packed {
        logic shift;
        logic load_id;
        logic load_qty;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/plom_req_if.sv */
// Request channel of the order matcher: valid/ready and one order beat.
// Depends on plom_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plom_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [plom_pkg::ID_W-1:0]   req_id;
    logic [plom_pkg::QTY_W-1:0]  quantity;

    modport source (output valid, output func, output req_id, output quantity,
                    input ready);
    modport sink   (input valid, input func, input req_id, input quantity,
                    output ready);
endinterface

`default_nettype wire

/* rtl/plom_rpt_if.sv */
// Report channel of the order matcher: valid/ready and one report beat.
// Depends on plom_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plom_rpt_if;
    logic                         valid;
    logic                         ready;
    logic [plom_pkg::KIND_W-1:0]  report_kind;
    logic [plom_pkg::ID_W-1:0]    resting_id;
    logic [plom_pkg::QTY_W-1:0]   fill_quantity;
    logic                         fully_filled;
    logic [plom_pkg::LEFT_W-1:0]  orders_left;
    logic                         last;

    modport source (output valid, output report_kind, output resting_id,
                    output fill_quantity, output fully_filled, output orders_left,
                    output last, input ready);
    modport sink   (input valid, input report_kind, input resting_id,
                    input fill_quantity, input fully_filled, input orders_left,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/plom_cell.sv */
// One queue cell: holds a resting order's id and quantity, shifts in its
// neighbor's entry on a pop. Depends on plom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plom_cell (
    input  wire                          i_clk,
    input  wire plom_pkg::t_cell_ctl     i_ctl,
    input  wire [plom_pkg::ID_W-1:0]     i_wr_id,
    input  wire [plom_pkg::QTY_W-1:0]    i_wr_qty,
    input  wire [plom_pkg::ID_W-1:0]     i_nb_id,
    input  wire [plom_pkg::QTY_W-1:0]    i_nb_qty,
    output logic [plom_pkg::ID_W-1:0]    o_id,
    output logic [plom_pkg::QTY_W-1:0]   o_qty
);

    logic [plom_pkg::ID_W-1:0]  r_id;
    logic [plom_pkg::QTY_W-1:0] r_qty;

    // Contents are only meaningful below the fill count, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_id  <= i_nb_id;
            r_qty <= i_nb_qty;
        end else begin
            if (i_ctl.load_id) begin
                r_id <= i_wr_id;
            end
            if (i_ctl.load_qty) begin
                r_qty <= i_wr_qty;
            end
        end
    end

    assign o_id  = r_id;
    assign o_qty = r_qty;

endmodule

`default_nettype wire

/* rtl/price_level_order_matcher_unit.sv */
// Price level order matcher: a row of plom_cell queue cells with the head
// in cell 0, plus the match controller. Depends on plom_pkg, plom_cell and
// the plom_req_if / plom_rpt_if interfaces.
// Usage: requests arrive on i_req (func 0 adds a resting order, func 1
// matches an incoming quantity); reports leave on o_rpt. Every request gives
// one or more report beats, and the final beat of a request has last set.
// A beat moves when valid and ready are both high.
// The first report is registered from the request beat. An add, a reject,
// an empty-level match or a single-order match gives one report. A match that
// walks the level produces one report per cycle while the receiver takes each
// beat, one per resting order touched, and at most MAX_REPORTS; the request
// side is held off until the walk has given its final report. The walk rate
// is set by the single head compare/subtract feeding the cell row each cycle.
// Reset (synchronous, active low) empties the level: the fill count, the
// walk state and the report valid clear; the cell contents are not reset,
// since cells above the fill count are never reported.
// When the receiver stalls, the report register holds its beat and no new
// step is taken, so the queue state does not advance until the beat moves.
// The next request is taken in the same cycle the previous final beat moves,
// so with o_rpt ready, back-to-back one-report requests run at one per cycle.
`timescale 1ns / 1ps
`default_nettype none

module price_level_order_matcher_unit #(
    parameter int QUEUE_DEPTH = plom_pkg::QUEUE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    plom_req_if.sink     i_req,
    plom_rpt_if.source   o_rpt
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Cell row outputs; cell 0 is the head of the level.
    logic [plom_pkg::ID_W-1:0]  w_id  [QUEUE_DEPTH];
    logic [plom_pkg::QTY_W-1:0] w_qty [QUEUE_DEPTH];

    plom_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [plom_pkg::QTY_W-1:0]  r_rem, n_rem;
    logic [plom_pkg::NREP_W-1:0] r_nrep, n_nrep;
    logic                        r_out_valid, n_out_valid;

    // Report register payload.
    logic [plom_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [plom_pkg::ID_W-1:0]   r_rid, n_rid;
    logic [plom_pkg::QTY_W-1:0]  r_fill, n_fill;
    logic                        r_full, n_full;
    logic [plom_pkg::LEFT_W-1:0] r_left, n_left;
    logic                        r_last, n_last;

    logic                        can_emit;
    logic                        emit;
    logic                        add_load;
    logic                        head_wr;
    logic                        do_shift;
    logic [plom_pkg::QTY_W-1:0]  rem_sel;
    logic [plom_pkg::QTY_W-1:0]  take;
    logic [plom_pkg::QTY_W-1:0]  rem_new;
    logic [plom_pkg::QTY_W-1:0]  head_left;
    logic                        head_le;
    logic [CNT_W-1:0]            cnt_step;
    logic [plom_pkg::NREP_W-1:0] nrep_step;
    logic                        step_last;
    logic [plom_pkg::QTY_W-1:0]  wr_qty;

    // The report register can take a new beat when empty or being drained.
    assign can_emit = !r_out_valid || o_rpt.ready;

    // One walk step against the head order. In idle the step uses the
    // incoming quantity, during a walk the remainder left by the last step.
    assign rem_sel   = (r_state == plom_pkg::S_IDLE) ? i_req.quantity : r_rem;
    assign head_le   = (w_qty[0] <= rem_sel);
    assign take      = head_le ? w_qty[0] : rem_sel;
    assign rem_new   = rem_sel - take;
    assign head_left = w_qty[0] - take;
    assign cnt_step  = head_le ? (r_count - CNT_W'(1)) : r_count;
    assign nrep_step = ((r_state == plom_pkg::S_IDLE) ? '0 : r_nrep)
                       + plom_pkg::NREP_W'(1);
    assign step_last = (rem_new == '0) || (cnt_step == '0)
                       || (nrep_step == plom_pkg::NREP_W'(plom_pkg::MAX_REPORTS));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_nrep      = r_nrep;
        emit        = 1'b0;
        add_load    = 1'b0;
        head_wr     = 1'b0;
        do_shift    = 1'b0;
        n_kind      = r_kind;
        n_rid       = r_rid;
        n_fill      = r_fill;
        n_full      = r_full;
        n_left      = r_left;
        n_last      = r_last;
        i_req.ready = 1'b0;

        unique case (r_state)
            plom_pkg::S_IDLE: begin
                i_req.ready = can_emit;
                if (i_req.valid && can_emit) begin
                    emit = 1'b1;
                    if (i_req.func == plom_pkg::FUNC_ADD) begin
                        n_rid  = i_req.req_id;
                        n_fill = '0;
                        n_full = 1'b0;
                        n_last = 1'b1;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_kind = plom_pkg::KIND_REJECT;
                            n_left = plom_pkg::LEFT_W'(r_count);
                        end else begin
                            add_load = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_kind   = plom_pkg::KIND_ACK;
                            n_left   = plom_pkg::LEFT_W'(r_count + CNT_W'(1));
                        end
                    end else if (r_count == '0) begin
                        n_kind = plom_pkg::KIND_NONE;
                        n_rid  = '0;
                        n_fill = '0;
                        n_full = 1'b0;
                        n_left = '0;
                        n_last = 1'b1;
                    end else begin
                        // An exact match of the head is the only fill kind.
                        do_shift = head_le;
                        head_wr  = !head_le;
                        n_count  = cnt_step;
                        n_rem    = rem_new;
                        n_nrep   = nrep_step;
                        n_kind   = (w_qty[0] == i_req.quantity) ? plom_pkg::KIND_FILL
                                                                : plom_pkg::KIND_PARTIAL;
                        n_rid    = w_id[0];
                        n_fill   = take;
                        n_full   = step_last && (rem_new == '0);
                        n_left   = plom_pkg::LEFT_W'(cnt_step);
                        n_last   = step_last;
                        n_state  = step_last ? plom_pkg::S_IDLE : plom_pkg::S_WALK;
                    end
                end
            end
            plom_pkg::S_WALK: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    do_shift = head_le;
                    head_wr  = !head_le;
                    n_count  = cnt_step;
                    n_rem    = rem_new;
                    n_nrep   = nrep_step;
                    n_kind   = plom_pkg::KIND_PARTIAL;
                    n_rid    = w_id[0];
                    n_fill   = take;
                    n_full   = step_last && (rem_new == '0);
                    n_left   = plom_pkg::LEFT_W'(cnt_step);
                    n_last   = step_last;
                    n_state  = step_last ? plom_pkg::S_IDLE : plom_pkg::S_WALK;
                end
            end
            default: begin
                n_state = plom_pkg::S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_rpt.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plom_pkg::S_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_nrep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_nrep      <= n_nrep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_rid  <= n_rid;
        r_fill <= n_fill;
        r_full <= n_full;
        r_left <= n_left;
        r_last <= n_last;
    end

    assign o_rpt.valid         = r_out_valid;
    assign o_rpt.report_kind   = r_kind;
    assign o_rpt.resting_id    = r_rid;
    assign o_rpt.fill_quantity = r_fill;
    assign o_rpt.fully_filled  = r_full;
    assign o_rpt.orders_left   = r_left;
    assign o_rpt.last          = r_last;

    // Shared write quantity: the reduced head on a partial step, else the
    // quantity of the order being added.
    assign wr_qty = head_wr ? head_left : i_req.quantity;

    // The cell row. A pop shifts every cell toward the head; an add loads
    // the cell at the fill count.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        plom_pkg::t_cell_ctl        w_ctl;
        logic [plom_pkg::ID_W-1:0]  w_nb_id;
        logic [plom_pkg::QTY_W-1:0] w_nb_qty;

        assign w_ctl = '{shift:    do_shift,
                         load_id:  add_load && (r_count == CNT_W'(gi)),
                         load_qty: (add_load && (r_count == CNT_W'(gi)))
                                   || ((gi == 0) && head_wr)};

        if (gi == QUEUE_DEPTH - 1) begin : g_end
            assign w_nb_id  = '0;
            assign w_nb_qty = '0;
        end else begin : g_mid
            assign w_nb_id  = w_id[gi + 1];
            assign w_nb_qty = w_qty[gi + 1];
        end

        plom_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_wr_id  (i_req.req_id),
            .i_wr_qty (wr_qty),
            .i_nb_id  (w_nb_id),
            .i_nb_qty (w_nb_qty),
            .o_id     (w_id[gi]),
            .o_qty    (w_qty[gi])
        );
    end

`ifndef SYNTHESIS
    // The fill count never exceeds the number of cells.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("order count above queue depth");

    // No request is taken while a walk is still producing reports.
    a_walk_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plom_pkg::S_WALK) |-> !i_req.ready)
        else $error("request accepted during walk");

    // A walk never runs past the report limit.
    a_walk_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plom_pkg::S_WALK) |->
            (r_nrep < plom_pkg::NREP_W'(plom_pkg::MAX_REPORTS)))
        else $error("walk exceeded report limit");

    // An empty-level report leaves the level empty and closes the request.
    a_none_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rpt.valid && (o_rpt.report_kind == plom_pkg::KIND_NONE)) |->
            ((r_count == '0) && o_rpt.last))
        else $error("no-orders report with resting orders");
`endif

endmodule

`default_nettype wire
